// ===== rtl/srr_pkg.sv =====
// Shared types and constants for the selective repeat reorder receiver.
`default_nettype none
package srr_pkg;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

	localparam logic [1:0] KIND_DATA_ACK  = 2'd0;
	localparam logic [1:0] KIND_COUNT_ACK = 2'd1;
	localparam logic [1:0] KIND_FILE_BYTE = 2'd2;
	localparam logic [1:0] KIND_DROPPED   = 2'd3;

	localparam int HEADER_BYTES = 8;
	localparam int FIELD_CHARS  = 4;
	localparam int ACC_W        = 14;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;

endpackage
`default_nettype wire

// ===== rtl/srr_store.sv =====
// Slot metadata memory with its clearing sweep, and the payload memory.
`default_nettype none
module srr_store #(
	parameter int MAX_PACKETS = 1024,
	parameter int SLOT_BYTES  = 1024
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	output logic                                            clear_busy,
	input  wire logic                                       meta_rd_en,
	input  wire logic [$clog2(MAX_PACKETS)-1:0]             meta_rd_idx,
	output logic                                            meta_rd_rcv,
	output logic [$clog2(SLOT_BYTES+1)-1:0]                 meta_rd_len,
	input  wire logic                                       meta_wr_en,
	input  wire logic [$clog2(MAX_PACKETS)-1:0]             meta_wr_idx,
	input  wire logic [$clog2(SLOT_BYTES+1)-1:0]            meta_wr_len,
	input  wire logic                                       pay_rd_en,
	input  wire logic [$clog2(MAX_PACKETS*SLOT_BYTES)-1:0]  pay_rd_addr,
	output logic [7:0]                                      pay_rd_data,
	input  wire logic                                       pay_wr_en,
	input  wire logic [$clog2(MAX_PACKETS*SLOT_BYTES)-1:0]  pay_wr_addr,
	input  wire logic [7:0]                                 pay_wr_data
);

	localparam int IW    = $clog2(MAX_PACKETS);
	localparam int LW    = $clog2(SLOT_BYTES + 1);
	localparam int DEPTH = MAX_PACKETS * SLOT_BYTES;

	logic [LW:0]    meta_mem [MAX_PACKETS];
	logic [7:0]     pay_mem  [DEPTH];
	logic [IW:0]    clr_q;
	logic [LW:0]    meta_rd_q;

	assign clear_busy = (clr_q != (IW+1)'(MAX_PACKETS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clear_busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clear_busy) begin
			meta_mem[clr_q[IW-1:0]] <= '0;
		end else if (meta_wr_en) begin
			meta_mem[meta_wr_idx] <= {1'b1, meta_wr_len};
		end
		if (meta_rd_en) begin
			meta_rd_q <= meta_mem[meta_rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (pay_wr_en) begin
			pay_mem[pay_wr_addr] <= pay_wr_data;
		end
		if (pay_rd_en) begin
			pay_rd_data <= pay_mem[pay_rd_addr];
		end
	end

	assign meta_rd_rcv = meta_rd_q[LW];
	assign meta_rd_len = meta_rd_q[LW-1:0];

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !meta_wr_en && !pay_wr_en)
		else $error("write during clearing sweep");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_busy |=> !clear_busy)
		else $error("clearing sweep restarted");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_busy |-> clr_q == (IW+1)'(MAX_PACKETS))
		else $error("sweep counter out of range");

endmodule
`default_nettype wire

// ===== rtl/selective_repeat_reorder_receiver_unit.sv =====
// Top level of the selective repeat reorder receiver.
// Each transfer on the input passes through the accept, memory read and update states, one item
// at a time, set by the registered read port of the slot and payload memories and the
// read-modify-write on them. After reset the slot marks are cleared by a sweep over all
// MAX_PACKETS slots, and in_ready stays low until the cycle after the sweep ends. A finished result
// sits in an output register while the next item is accepted; the update of that item waits until
// the register is free.
`default_nettype none
module selective_repeat_reorder_receiver_unit #(
	parameter int MAX_PACKETS = 1024,
	parameter int SLOT_BYTES  = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [7:0]  data_byte,
	input  wire logic        datagram_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       result_kind,
	output logic [9:0]       ack_id,
	output logic [7:0]       file_byte,
	output logic             packet_last_byte,
	output logic             transfer_done,
	output logic [10:0]      window_base
);

	localparam int IW  = $clog2(MAX_PACKETS);
	localparam int CW  = $clog2(MAX_PACKETS + 1);
	localparam int LW  = $clog2(SLOT_BYTES + 1);
	localparam int OW  = $clog2(SLOT_BYTES);
	localparam int PAW = $clog2(MAX_PACKETS * SLOT_BYTES);
	localparam int PMAX = srr_pkg::HEADER_BYTES + SLOT_BYTES;
	localparam int PW  = $clog2(PMAX + 1);
	localparam int AW  = srr_pkg::ACC_W;

	srr_pkg::state_t state_q, state_d;

	logic            cmd_q, end_q;
	logic [7:0]      byte_q;
	logic [PW-1:0]   pos_q;
	logic [AW-1:0]   id_q, size_q;
	logic            neg_q, storing_q;
	logic [CW-1:0]   total_q, next_q;
	logic            known_q;
	logic [OW-1:0]   off_q;

	logic            clear_busy;
	logic            meta_rd_en, meta_rd_rcv, meta_wr_en;
	logic [IW-1:0]   meta_rd_idx;
	logic [LW-1:0]   meta_rd_len;
	logic            pay_rd_en, pay_wr_en;
	logic [PAW-1:0]  pay_rd_addr, pay_wr_addr;
	logic [7:0]      pay_rd_data;

	logic            exec_go;

	logic [PW-1:0]   pos_n;
	logic [AW-1:0]   id_n, size_n;
	logic            neg_n, storing_n;
	logic [CW-1:0]   total_n, next_n;
	logic            known_n;
	logic [OW-1:0]   off_n;
	logic            res_v;
	logic [1:0]      res_kind;
	logic [9:0]      res_ack;
	logic [7:0]      res_byte;
	logic            res_last;
	logic            data_ok;
	logic [AW-1:0]   acc_sel;
	logic [AW-1:0]   acc_new;
	logic [31:0]     pay_off;

	always_comb begin
		state_d = state_q;
		case (state_q)
			srr_pkg::ST_CLEAR: if (!clear_busy) state_d = srr_pkg::ST_IDLE;
			srr_pkg::ST_IDLE:  if (in_valid) state_d = srr_pkg::ST_READ;
			srr_pkg::ST_READ:  state_d = srr_pkg::ST_EXEC;
			srr_pkg::ST_EXEC:  if (exec_go) state_d = srr_pkg::ST_IDLE;
			default:           state_d = srr_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		meta_rd_en = 1'b0;
		pay_rd_en  = 1'b0;
		case (state_q)
			srr_pkg::ST_IDLE: in_ready = 1'b1;
			srr_pkg::ST_READ: begin
				meta_rd_en = 1'b1;
				pay_rd_en  = cmd_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srr_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign exec_go     = !out_valid || out_ready;
	assign meta_rd_idx = cmd_q ? next_q[IW-1:0] : id_q[IW-1:0];
	assign pay_rd_addr = PAW'(next_q[IW-1:0]) * PAW'(SLOT_BYTES) + PAW'(off_q);

	always_comb begin
		pos_n     = pos_q;
		id_n      = id_q;
		size_n    = size_q;
		neg_n     = neg_q;
		storing_n = storing_q;
		total_n   = total_q;
		next_n    = next_q;
		known_n   = known_q;
		off_n     = off_q;
		res_v     = 1'b0;
		res_kind  = srr_pkg::KIND_DROPPED;
		res_ack   = '0;
		res_byte  = '0;
		res_last  = 1'b0;
		meta_wr_en  = 1'b0;
		pay_wr_en   = 1'b0;
		pay_off     = 32'(pos_q) - 32'(srr_pkg::HEADER_BYTES);
		pay_wr_addr = PAW'(id_q[IW-1:0]) * PAW'(SLOT_BYTES) + PAW'(pay_off);
		acc_sel   = (32'(pos_q) < srr_pkg::FIELD_CHARS) ? id_q : size_q;
		acc_new   = (acc_sel << 3) + (acc_sel << 1) + AW'(byte_q - srr_pkg::CHAR_ZERO);
		data_ok   = 1'b0;
		if (cmd_q) begin
			if (known_q && next_q < total_q && meta_rd_rcv) begin
				res_v    = 1'b1;
				res_kind = srr_pkg::KIND_FILE_BYTE;
				res_byte = pay_rd_data;
				res_last = (32'(off_q) + 32'd1 >= 32'(meta_rd_len));
				if (res_last) begin
					next_n = next_q + 1'b1;
					off_n  = '0;
				end else begin
					off_n = off_q + 1'b1;
				end
			end
		end else begin
			if (32'(pos_q) < srr_pkg::HEADER_BYTES) begin
				if (byte_q >= srr_pkg::CHAR_ZERO && byte_q <= srr_pkg::CHAR_NINE) begin
					if (32'(pos_q) < srr_pkg::FIELD_CHARS) id_n = acc_new;
					else size_n = acc_new;
				end else if (byte_q == srr_pkg::CHAR_MINUS &&
					32'(pos_q) >= srr_pkg::FIELD_CHARS) begin
					neg_n = 1'b1;
				end
			end else if (storing_q && pay_off < 32'(size_q) && pay_off < SLOT_BYTES) begin
				pay_wr_en = 1'b1;
			end
			data_ok = known_q && !neg_n && size_n != '0 && 32'(size_n) <= SLOT_BYTES &&
				32'(id_n) < 32'(total_q);
			if (32'(pos_q) == srr_pkg::HEADER_BYTES - 1) begin
				storing_n = data_ok && !meta_rd_rcv;
			end
			if (32'(pos_q) < PMAX) begin
				pos_n = pos_q + 1'b1;
			end
			if (end_q) begin
				res_v = 1'b1;
				if (32'(pos_n) < srr_pkg::HEADER_BYTES) begin
					res_kind = srr_pkg::KIND_DROPPED;
				end else if (neg_n || size_n == '0) begin
					res_kind = srr_pkg::KIND_COUNT_ACK;
					if (!known_q) begin
						known_n = 1'b1;
						total_n = (32'(id_n) > MAX_PACKETS) ? CW'(MAX_PACKETS) : CW'(id_n);
						next_n  = '0;
						off_n   = '0;
					end
				end else if (!data_ok) begin
					res_kind = srr_pkg::KIND_DROPPED;
				end else if (meta_rd_rcv) begin
					res_kind = srr_pkg::KIND_DATA_ACK;
					res_ack  = id_n[9:0];
				end else if (32'(pos_n) - 32'(srr_pkg::HEADER_BYTES) >= 32'(size_n)) begin
					res_kind   = srr_pkg::KIND_DATA_ACK;
					res_ack    = id_n[9:0];
					meta_wr_en = 1'b1;
				end else begin
					res_kind = srr_pkg::KIND_DROPPED;
				end
				pos_n     = '0;
				id_n      = '0;
				size_n    = '0;
				neg_n     = 1'b0;
				storing_n = 1'b0;
			end
		end
		if (!(state_q == srr_pkg::ST_EXEC && exec_go)) begin
			meta_wr_en = 1'b0;
			pay_wr_en  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			id_q      <= '0;
			size_q    <= '0;
			neg_q     <= 1'b0;
			storing_q <= 1'b0;
			total_q   <= '0;
			next_q    <= '0;
			known_q   <= 1'b0;
			off_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == srr_pkg::ST_EXEC && exec_go) begin
				pos_q     <= pos_n;
				id_q      <= id_n;
				size_q    <= size_n;
				neg_q     <= neg_n;
				storing_q <= storing_n;
				total_q   <= total_n;
				next_q    <= next_n;
				known_q   <= known_n;
				off_q     <= off_n;
				out_valid <= res_v;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= command;
			byte_q <= data_byte;
			end_q  <= datagram_end;
		end
		if (state_q == srr_pkg::ST_EXEC && exec_go && res_v) begin
			result_kind      <= res_kind;
			ack_id           <= res_ack;
			file_byte        <= res_byte;
			packet_last_byte <= res_last;
			transfer_done    <= known_n && next_n >= total_n;
			window_base      <= 11'(next_n);
		end
	end

	srr_store #(
		.MAX_PACKETS(MAX_PACKETS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear_busy (clear_busy),
		.meta_rd_en (meta_rd_en),
		.meta_rd_idx(meta_rd_idx),
		.meta_rd_rcv(meta_rd_rcv),
		.meta_rd_len(meta_rd_len),
		.meta_wr_en (meta_wr_en),
		.meta_wr_idx(id_q[IW-1:0]),
		.meta_wr_len(LW'(size_q)),
		.pay_rd_en  (pay_rd_en),
		.pay_rd_addr(pay_rd_addr),
		.pay_rd_data(pay_rd_data),
		.pay_wr_en  (pay_wr_en),
		.pay_wr_addr(pay_wr_addr),
		.pay_wr_data(byte_q)
	);

	a_done_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transfer_done |-> known_q)
		else $error("transfer done before the packet count is known");

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		known_q |-> next_q <= total_q)
		else $error("in-order window passed the packet count");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !in_ready)
		else $error("input accepted during clearing sweep");

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(off_q) < SLOT_BYTES)
		else $error("drain offset past the slot");

endmodule
`default_nettype wire
